### src/c_subset_lexer_top_assert.svh
// Assertion macros shared by the lexer modules.
// Each macro expects signals clk and rst_n in the scope where it is used.
`ifndef C_SUBSET_LEXER_TOP_ASSERT_SVH
`define C_SUBSET_LEXER_TOP_ASSERT_SVH

// A condition that holds at every clock edge outside reset.
`define CLX_ASSERT_ALWAYS(name, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// A condition that implies another in the same cycle.
`define CLX_ASSERT_IMPLIES(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// A condition that implies another in the next cycle.
`define CLX_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/clx_pkg.sv
// Shared types and constants for the C-subset lexer.
// No dependencies; the front, queue, back and top modules import this package.
package clx_pkg;

    // Lexer modes.
    typedef enum logic [3:0] {
        M_IDLE  = 4'd0,
        M_WORD  = 4'd1,
        M_OPER  = 4'd2,
        M_CHR   = 4'd3,
        M_STR   = 4'd4,
        M_SLASH = 4'd5,
        M_BOPEN = 4'd6,
        M_BBODY = 4'd7,
        M_BSTAR = 4'd8,
        M_LINE  = 4'd9
    } mode_t;

    // Token kinds.
    localparam logic [2:0] K_WORD   = 3'd0;
    localparam logic [2:0] K_OPER   = 3'd1;
    localparam logic [2:0] K_CHR    = 3'd2;
    localparam logic [2:0] K_STR    = 3'd3;
    localparam logic [2:0] K_SINGLE = 3'd4;

    // Width of the line count carried in each result.
    localparam int LINE_OUT_W = 16;

    // Queue between front and back.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // One result word without its line count.
    typedef struct packed {
        logic [7:0] data;
        logic       start;
        logic [2:0] kind;
        logic       stream_end;
        logic       unterm;
    } result_t;

    // All results of one input word: one or two, sharing one line count.
    typedef struct packed {
        result_t                 first;
        result_t                 second;
        logic                    two;
        logic [LINE_OUT_W-1:0]   lines;
    } entry_t;

    // Queue status seen by the front and back.
    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

### src/clx_if.sv
// Valid/ready channel interfaces for the lexer input and output words.
// No dependencies.
interface clx_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_input;

    modport source (output valid, output in_byte, output end_of_input, input ready);
    modport sink (input valid, input in_byte, input end_of_input, output ready);
endinterface

interface clx_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic        token_start;
    logic [2:0]  token_kind;
    logic        stream_end;
    logic        unterminated;
    logic [15:0] line_count;

    modport source (output valid, output out_byte, output token_start, output token_kind,
                    output stream_end, output unterminated, output line_count, input ready);
    modport sink (input valid, input out_byte, input token_start, input token_kind,
                  input stream_end, input unterminated, input line_count, output ready);
endinterface

### src/clx_front.sv
// Front end of the lexer: accepts bytes, runs the mode machine and the
// line counter, and builds one queue entry of up to two results per byte.
// Depends on clx_pkg, clx_if and the assertion macro header.
`include "c_subset_lexer_top_assert.svh"

module clx_front #(
    parameter int LINE_BITS = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    clx_in_if.sink          in_ch,
    input  clx_pkg::q_stat_t qstat,
    output clx_pkg::entry_t ent,
    output logic            push
);
    import clx_pkg::*;

    localparam logic [7:0] CH_TAB    = 8'd9;
    localparam logic [7:0] CH_NL     = 8'd10;
    localparam logic [7:0] CH_CR     = 8'd13;
    localparam logic [7:0] CH_SPACE  = 8'd32;
    localparam logic [7:0] CH_DQUOTE = 8'd34;
    localparam logic [7:0] CH_DOLLAR = 8'd36;
    localparam logic [7:0] CH_QUOTE  = 8'd39;
    localparam logic [7:0] CH_STAR   = 8'd42;
    localparam logic [7:0] CH_SLASH  = 8'd47;
    localparam logic [7:0] CH_UNDER  = 8'd95;
    localparam logic [LINE_BITS-1:0] LINE_MAX = {LINE_BITS{1'b1}};

    function automatic logic is_space(input logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_NL || c == CH_CR;
    endfunction

    function automatic logic is_word(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
               (c >= "0" && c <= "9") || c == CH_UNDER || c == CH_DOLLAR;
    endfunction

    function automatic logic is_oper(input logic [7:0] c);
        return c == "<" || c == "=" || c == ">" || c == "|" ||
               c == "&" || c == "!" || c == "+" || c == "-";
    endfunction

    // A byte handled between tokens gives a result unless it is blank or a slash.
    function automatic logic free_emits(input logic [7:0] c);
        return !is_space(c) && c != CH_SLASH;
    endfunction

    function automatic result_t free_res(input logic [7:0] c, input mode_t m);
        result_t r;
        r.data       = c;
        r.stream_end = 1'b0;
        r.unterm     = 1'b0;
        if (is_word(c))
        begin
            r.start = (m != M_WORD);
            r.kind  = K_WORD;
        end
        else if (is_oper(c))
        begin
            r.start = (m != M_OPER);
            r.kind  = K_OPER;
        end
        else if (c == CH_QUOTE)
        begin
            r.start = 1'b1;
            r.kind  = K_CHR;
        end
        else if (c == CH_DQUOTE)
        begin
            r.start = 1'b1;
            r.kind  = K_STR;
        end
        else
        begin
            r.start = 1'b1;
            r.kind  = K_SINGLE;
        end
        return r;
    endfunction

    function automatic mode_t free_mode(input logic [7:0] c);
        mode_t m;
        if (is_word(c))
            m = M_WORD;
        else if (is_oper(c))
            m = M_OPER;
        else if (c == CH_QUOTE)
            m = M_CHR;
        else if (c == CH_DQUOTE)
            m = M_STR;
        else if (c == CH_SLASH)
            m = M_SLASH;
        else
            m = M_IDLE;
        return m;
    endfunction

    mode_t                mode_reg, mode_next;
    logic [LINE_BITS-1:0] lines_reg, lines_next;
    logic                 accept;
    logic [7:0]           c;
    logic                 eoi;
    logic [1:0]           n_res;
    result_t              slash_res;
    result_t              end_res;

    assign c         = in_ch.in_byte;
    assign eoi       = in_ch.end_of_input;
    assign in_ch.ready = !qstat.full;
    assign accept    = in_ch.valid && in_ch.ready;

    assign slash_res = '{data: CH_SLASH, start: 1'b1, kind: K_SINGLE,
                         stream_end: 1'b0, unterm: 1'b0};
    assign end_res   = '{data: 8'd0, start: 1'b0, kind: K_WORD, stream_end: 1'b1,
                         unterm: (mode_reg == M_CHR || mode_reg == M_STR ||
                                  mode_reg == M_BOPEN || mode_reg == M_BBODY ||
                                  mode_reg == M_BSTAR || mode_reg == M_LINE)};

    // Next mode.
    always_comb
    begin
        mode_next = mode_reg;
        if (eoi)
            mode_next = M_IDLE;
        else
        begin
            unique case (mode_reg)
                M_CHR:   mode_next = (c == CH_QUOTE) ? M_IDLE : M_CHR;
                M_STR:   mode_next = (c == CH_DQUOTE) ? M_IDLE : M_STR;
                M_SLASH:
                begin
                    if (c == CH_STAR)
                        mode_next = M_BOPEN;
                    else if (c == CH_SLASH)
                        mode_next = M_LINE;
                    else
                        mode_next = free_mode(c);
                end
                M_BOPEN, M_BSTAR:
                begin
                    if (c == CH_SLASH)
                        mode_next = M_IDLE;
                    else if (c == CH_STAR)
                        mode_next = M_BSTAR;
                    else
                        mode_next = M_BBODY;
                end
                M_BBODY: mode_next = (c == CH_STAR) ? M_BSTAR : M_BBODY;
                M_LINE:  mode_next = (c == CH_NL) ? M_IDLE : M_LINE;
                default: mode_next = free_mode(c);
            endcase
        end
    end

    // Results of the current byte.
    always_comb
    begin
        ent.first  = slash_res;
        ent.second = end_res;
        n_res      = 2'd0;
        if (eoi)
        begin
            if (mode_reg == M_SLASH)
                n_res = 2'd2;
            else
            begin
                ent.first = end_res;
                n_res     = 2'd1;
            end
        end
        else
        begin
            unique case (mode_reg)
                M_CHR, M_STR:
                begin
                    ent.first = '{data: c, start: 1'b0,
                                  kind: (mode_reg == M_CHR) ? K_CHR : K_STR,
                                  stream_end: 1'b0, unterm: 1'b0};
                    n_res = 2'd1;
                end
                M_SLASH:
                begin
                    // A slash not opening a comment goes out first, then the byte unless it is blank.
                    if (c != CH_STAR && c != CH_SLASH)
                    begin
                        ent.second = free_res(c, M_IDLE);
                        n_res      = free_emits(c) ? 2'd2 : 2'd1;
                    end
                end
                M_BOPEN, M_BSTAR, M_BBODY, M_LINE:
                    n_res = 2'd0;
                default:
                begin
                    ent.first = free_res(c, mode_reg);
                    n_res     = free_emits(c) ? 2'd1 : 2'd0;
                end
            endcase
        end
        ent.two   = (n_res == 2'd2);
        ent.lines = LINE_OUT_W'(lines_reg);
    end

    assign push = accept && (n_res != 2'd0);

    // Line feeds count everywhere but inside literals, saturating at the top.
    always_comb
    begin
        lines_next = lines_reg;
        if (!eoi && c == CH_NL && mode_reg != M_CHR && mode_reg != M_STR &&
            lines_reg != LINE_MAX)
            lines_next = lines_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= M_IDLE;
            lines_reg <= '0;
        end
        else if (accept)
        begin
            mode_reg  <= mode_next;
            lines_reg <= lines_next;
        end
    end

    `CLX_ASSERT_NEXT(a_lines_monotonic, 1'b1, lines_reg >= $past(lines_reg), "line count went down")

endmodule

### src/clx_queue.sv
// Short queue of result entries between the lexer front and back.
// Depends on clx_pkg and the assertion macro header.
`include "c_subset_lexer_top_assert.svh"

module clx_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  clx_pkg::entry_t  push_ent,
    input  logic             pop,
    output clx_pkg::entry_t  head,
    output clx_pkg::q_stat_t qstat
);
    import clx_pkg::*;

    entry_t              store_reg [QDEPTH];
    logic [QPTR_W-1:0]   wptr_reg, rptr_reg;
    logic [QCNT_W-1:0]   count_reg, count_next;

    assign head        = store_reg[rptr_reg];
    assign qstat.full  = (count_reg == QCNT_W'(QDEPTH));
    assign qstat.empty = (count_reg == '0);

    // Occupancy follows pushes and pops.
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
                wptr_reg <= wptr_reg + 1'b1;
            if (pop)
                rptr_reg <= rptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
            store_reg[wptr_reg] <= push_ent;
    end

    `CLX_ASSERT_IMPLIES(a_no_push_full, qstat.full, !push, "push into full queue")
    `CLX_ASSERT_IMPLIES(a_no_pop_empty, qstat.empty, !pop, "pop from empty queue")
    `CLX_ASSERT_ALWAYS(a_ptr_gap, QPTR_W'(wptr_reg - rptr_reg) == QPTR_W'(count_reg), "pointers and count disagree")

endmodule

### src/clx_back.sv
// Back end of the lexer: takes entries from the queue and sends their
// results one word per cycle, while out_ch.ready holds, through an output register.
// Depends on clx_pkg, clx_if and the assertion macro header.
`include "c_subset_lexer_top_assert.svh"

module clx_back (
    input  logic             clk,
    input  logic             rst_n,
    input  clx_pkg::entry_t  head,
    input  clx_pkg::q_stat_t qstat,
    output logic             pop,
    clx_out_if.source        out_ch
);
    import clx_pkg::*;

    result_t               out_reg;
    logic [LINE_OUT_W-1:0] lines_reg;
    logic                  valid_reg, valid_next;
    logic                  half_reg, half_next;
    logic                  load;

    // The output register may refill whenever it is empty or being taken.
    assign load = !valid_reg || out_ch.ready;

    always_comb
    begin
        valid_next = valid_reg;
        half_next  = half_reg;
        pop        = 1'b0;
        if (load)
        begin
            valid_next = !qstat.empty;
            if (!qstat.empty)
            begin
                if (head.two && !half_reg)
                    half_next = 1'b1;
                else
                begin
                    half_next = 1'b0;
                    pop       = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            half_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            half_reg  <= half_next;
        end
    end

    // Payload of the output word.
    always_ff @(posedge clk)
    begin
        if (load && !qstat.empty)
        begin
            out_reg   <= half_reg ? head.second : head.first;
            lines_reg <= head.lines;
        end
    end

    assign out_ch.valid        = valid_reg;
    assign out_ch.out_byte     = out_reg.data;
    assign out_ch.token_start  = out_reg.start;
    assign out_ch.token_kind   = out_reg.kind;
    assign out_ch.stream_end   = out_reg.stream_end;
    assign out_ch.unterminated = out_reg.unterm;
    assign out_ch.line_count   = lines_reg;

    `CLX_ASSERT_IMPLIES(a_half_has_entry, half_reg, !qstat.empty && head.two, "second half without a two-result entry")

endmodule

### src/c_subset_lexer_top.sv
// Top level of the C-subset lexer: front end, result queue and back end.
// Depends on clx_pkg, clx_if, clx_front, clx_queue and clx_back.
//
//  channel   dir  handshake      word contents
//  in_ch     in   valid / ready  in_byte, end_of_input
//  out_ch    out  valid / ready  out_byte, token_start, token_kind,
//                                stream_end, unterminated, line_count
//
// One input byte is taken per cycle, stalling only when the queue is full;
// it goes through the queue and the output register to out_ch. A byte that
// gives two results (a byte or the end marker after a held slash) fills the
// single output register twice; the queue of four entries absorbs that.
// Reset is asynchronous, active low: mode idle, line count zero, queue empty.
// in_ch.ready depends only on queue occupancy, not on out_ch.ready.
module c_subset_lexer_top #(
    parameter int LINE_BITS = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    clx_in_if.sink    in_ch,
    clx_out_if.source out_ch
);
    import clx_pkg::*;

    entry_t  push_ent;
    entry_t  head;
    q_stat_t qstat;
    logic    push;
    logic    pop;

    clx_front #(
        .LINE_BITS(LINE_BITS)
    ) u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .in_ch (in_ch),
        .qstat (qstat),
        .ent   (push_ent),
        .push  (push)
    );

    clx_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_ent (push_ent),
        .pop      (pop),
        .head     (head),
        .qstat    (qstat)
    );

    clx_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .qstat  (qstat),
        .pop    (pop),
        .out_ch (out_ch)
    );

endmodule
